FILE: hdl/hfsl_pkg.sv
// shared types, constants and the binomial table for the scaled hmm forward unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package hfsl_pkg;

	localparam int MAX_STATES_DEF = 8;
	localparam int QUEUE_DEPTH    = 4;

	localparam int PROB_W   = 32;
	localparam int ACC_W    = 48;
	localparam int TOT_W    = 48;
	localparam int SCALE_W  = 32;
	localparam int SUM_W    = 52;
	localparam int FRAC_W   = 16;
	localparam int CNT_W    = 6;
	localparam int MUL_A_W  = 44;
	localparam int MUL_B_W  = 32;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int LOG_STEPS = 28;
	localparam int DIV_STEPS = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [PROB_W-1:0]  ONE_Q31       = 32'h8000_0000;
	localparam logic [ACC_W-1:0]   ACC_MAX       = '1;
	localparam logic [29:0]        LN2_Q30       = 30'd744261118;
	localparam logic [FRAC_W-1:0]  PRIOR_FRAC_RST = 16'd655;
	localparam logic [3:0]         STATE_CNT_RST  = 4'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRIOR_FRAC  = 1'b0,
		CFG_STATE_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		OP_TRANS = 1'b0,
		OP_EMIT  = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [2:0]        from_state;
		logic [2:0]        to_state;
		logic              to_ok;
		logic [PROB_W-1:0] prob;
		logic              first_locus;
		logic              locus_done;
		logic              seq_end;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_TR_MUL,
		B_TR_ADD,
		B_PRI_STEP,
		B_PRI_UPD,
		B_PRI_MUL,
		B_PRI_WR,
		B_EM_HI,
		B_EM_LO,
		B_EM_WR,
		B_CHK,
		B_SUM,
		B_ZCHK,
		B_LZ,
		B_SQ_MUL,
		B_SQ_UPD,
		B_LN_MUL,
		B_LN_RND,
		B_DV_INIT,
		B_DV_STEP,
		B_DV_RND,
		B_TOT
	} back_state_t;

	// pascal triangle, folds to constants; rows up to 15 fit 14 bits
	function automatic logic [13:0] binom_coef(input logic [3:0] n, input logic [3:0] z);
		logic [13:0] pas [0:15][0:15];
		int r;
		int c;
		for (r = 0; r < 16; r++) begin
			for (c = 0; c < 16; c++) begin
				if (c == 0)
					pas[r][c] = 14'd1;
				else if (r == 0)
					pas[r][c] = 14'd0;
				else
					pas[r][c] = pas[r-1][c-1] + pas[r-1][c];
			end
		end
		return pas[n][z];
	endfunction

endpackage

FILE: hdl/hfsl_front.sv
// front end: takes input transfers, saturates the probability, range checks
// state indices and drops entries with no effect; depends on hfsl_pkg
`timescale 1ns / 1ps

module hfsl_front #(
	parameter int MAX_STATES = hfsl_pkg::MAX_STATES_DEF,
	localparam int N_W = $clog2(MAX_STATES + 1)
) (
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [2:0]                   from_state,
	input  logic [2:0]                   to_state,
	input  logic [hfsl_pkg::PROB_W-1:0]  prob,
	input  logic                         first_locus,
	input  logic                         locus_done,
	input  logic                         sequence_end,
	input  logic [N_W-1:0]               n_active,
	input  hfsl_pkg::q_stat_t            q_stat,
	output logic                         push,
	output hfsl_pkg::entry_t             entry
);

	logic from_ok;
	logic to_ok;
	logic keep;

	always_comb begin
		from_ok = 32'(from_state) < 32'(n_active);
		to_ok   = 32'(to_state) < 32'(n_active);
		if (hfsl_pkg::op_t'(op) == hfsl_pkg::OP_EMIT)
			keep = to_ok || locus_done;
		else
			keep = from_ok && to_ok && !first_locus;

		entry.op          = hfsl_pkg::op_t'(op);
		entry.from_state  = from_state;
		entry.to_state    = to_state;
		entry.to_ok       = to_ok;
		entry.prob        = (prob > hfsl_pkg::ONE_Q31) ? hfsl_pkg::ONE_Q31 : prob;
		entry.first_locus = first_locus;
		entry.locus_done  = locus_done;
		entry.seq_end     = sequence_end && locus_done;

		in_ready = !q_stat.full;
		push     = in_valid && !q_stat.full && keep;
	end

endmodule

FILE: hdl/hfsl_queue.sv
// short entry queue between front and back end
// depends on hfsl_pkg
`timescale 1ns / 1ps

module hfsl_queue #(
	parameter int DEPTH = hfsl_pkg::QUEUE_DEPTH,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hfsl_pkg::entry_t  wr_entry,
	input  logic              pop,
	output hfsl_pkg::entry_t  rd_entry,
	output hfsl_pkg::q_stat_t stat
);

	hfsl_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_comb begin
		rd_entry   = mem_q[rd_ptr_q];
		stat.full  = 32'(count_q) == DEPTH;
		stat.empty = count_q == '0;
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (32'(count_q) < DEPTH || pop))
		else $error("queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");

endmodule

FILE: hdl/hfsl_back.sv
// back end: forward vector storage, prior, locus close with log and normalise,
// result register; one shared registered multiplier; depends on hfsl_pkg
`timescale 1ns / 1ps

module hfsl_back #(
	parameter int MAX_STATES = hfsl_pkg::MAX_STATES_DEF,
	localparam int N_W  = $clog2(MAX_STATES + 1),
	localparam int ST_W = $clog2(MAX_STATES)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [N_W-1:0]                 n_active,
	input  logic [hfsl_pkg::FRAC_W-1:0]    prior_frac,
	input  hfsl_pkg::entry_t               head,
	input  hfsl_pkg::q_stat_t              q_stat,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [hfsl_pkg::SCALE_W-1:0] locus_log_scale,
	output logic signed [hfsl_pkg::TOT_W-1:0]   running_log_like,
	output logic                           zero_sum,
	output logic                           final_res
);

	localparam int CW = hfsl_pkg::CNT_W;

	hfsl_pkg::back_state_t state_q, state_d;

	hfsl_pkg::entry_t ent_q;
	logic             first_q;
	logic             in_first_q;
	logic signed [hfsl_pkg::TOT_W-1:0] total_q;
	logic [hfsl_pkg::PROB_W-1:0] prev_q [MAX_STATES];
	logic [hfsl_pkg::ACC_W-1:0]  acc_q  [MAX_STATES];

	logic [CW-1:0]  cnt_q;
	logic [N_W-1:0] idx_q;
	logic [hfsl_pkg::MUL_A_W-1:0] pri_q;
	logic [55:0]    ahi_q;
	logic [hfsl_pkg::SUM_W-1:0] sum_q;
	logic [hfsl_pkg::SUM_W-1:0] lz_q;
	logic [5:0]     e_q;
	logic [30:0]    x_q;
	logic [27:0]    frac_q;
	logic           neg_q;
	logic signed [hfsl_pkg::SCALE_W-1:0] scale_q;
	logic           zero_q;
	logic [hfsl_pkg::SUM_W:0] r_q;
	logic [32:0]    q_q;
	logic [hfsl_pkg::PROD_W-1:0] prod_q;

	logic out_valid_q;
	logic signed [hfsl_pkg::SCALE_W-1:0] res_scale_q;
	logic signed [hfsl_pkg::TOT_W-1:0]   res_tot_q;
	logic res_zero_q;
	logic res_final_q;

	logic [ST_W-1:0] acc_ra;
	logic [hfsl_pkg::ACC_W-1:0]  acc_rd;
	logic [hfsl_pkg::PROB_W-1:0] prev_rd;
	logic [hfsl_pkg::MUL_A_W-1:0] mul_a;
	logic [hfsl_pkg::MUL_B_W-1:0] mul_b;
	logic [16:0]    fac;
	logic [hfsl_pkg::PROB_W-1:0] pri_sat;
	logic [64:0]    rnd31;
	logic [48:0]    tr_sum;
	logic [61:0]    pri_upd;
	logic [79:0]    em_full;
	logic [31:0]    sq_t;
	logic signed [6:0]  e_s;
	logic signed [34:0] v_w;
	logic [34:0]    mag;
	logic [64:0]    ln_rnd;
	logic [hfsl_pkg::SUM_W:0] dv_rr;
	logic [32:0]    dv_qq;
	logic           dv_ge;
	logic [32:0]    dv_q1;
	logic [48:0]    tot_sum;
	logic signed [hfsl_pkg::TOT_W-1:0] tot_sat;
	logic           out_free;
	logic [CW-1:0]  n_m1;
	logic           head_first;

	// read ports and arithmetic around the shared multiplier
	always_comb begin
		if (state_q == hfsl_pkg::B_SUM || state_q == hfsl_pkg::B_DV_INIT)
			acc_ra = ST_W'(idx_q);
		else
			acc_ra = ST_W'(ent_q.to_state);
		acc_rd  = acc_q[acc_ra];
		prev_rd = prev_q[ST_W'(ent_q.from_state)];

		n_m1 = CW'(n_active) - 1'b1;
		fac  = (cnt_q < CW'(ent_q.to_state)) ? {1'b0, prior_frac}
		                                     : 17'h10000 - {1'b0, prior_frac};
		pri_sat = (pri_q > hfsl_pkg::MUL_A_W'(hfsl_pkg::ONE_Q31)) ? hfsl_pkg::ONE_Q31
		                                                          : pri_q[31:0];

		e_s = $signed({1'b0, e_q}) - 7'sd31;
		v_w = $signed({e_s, 28'd0}) + $signed({7'd0, frac_q});
		mag = v_w[34] ? 35'(-v_w) : 35'(v_w);

		case (state_q)
			hfsl_pkg::B_TR_MUL: begin
				mul_a = hfsl_pkg::MUL_A_W'(prev_rd);
				mul_b = ent_q.prob;
			end
			hfsl_pkg::B_PRI_STEP: begin
				mul_a = pri_q;
				mul_b = 32'(fac);
			end
			hfsl_pkg::B_PRI_MUL: begin
				mul_a = hfsl_pkg::MUL_A_W'(pri_sat);
				mul_b = ent_q.prob;
			end
			hfsl_pkg::B_EM_HI: begin
				mul_a = hfsl_pkg::MUL_A_W'(acc_rd[47:24]);
				mul_b = ent_q.prob;
			end
			hfsl_pkg::B_EM_LO: begin
				mul_a = hfsl_pkg::MUL_A_W'(acc_rd[23:0]);
				mul_b = ent_q.prob;
			end
			hfsl_pkg::B_SQ_MUL: begin
				mul_a = hfsl_pkg::MUL_A_W'(x_q);
				mul_b = 32'(x_q);
			end
			hfsl_pkg::B_LN_MUL: begin
				mul_a = hfsl_pkg::MUL_A_W'(mag);
				mul_b = 32'(hfsl_pkg::LN2_Q30);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		// half-up rounding of a q1.31 product
		rnd31   = {1'b0, prod_q[63:0]} + 65'(64'd1 << 30);
		tr_sum  = {1'b0, acc_rd} + 49'(rnd31[64:31]);
		pri_upd = {1'b0, prod_q[60:0]} + 62'd32768;
		em_full = {ahi_q, 24'd0} + 80'(prod_q[55:0]) + 80'(64'd1 << 30);
		sq_t    = prod_q[61:30];
		ln_rnd  = {1'b0, prod_q[63:0]} + 65'(64'd1 << 33);

		dv_rr = (cnt_q == '0) ? r_q : {r_q[hfsl_pkg::SUM_W-1:0], 1'b0};
		dv_qq = (cnt_q == '0) ? q_q : {q_q[31:0], 1'b0};
		dv_ge = dv_rr >= {1'b0, sum_q};
		dv_q1 = q_q + 33'({r_q, 1'b0} >= {2'b0, sum_q});

		tot_sum = (first_q ? 49'd0 : {total_q[47], total_q})
		        + {{17{scale_q[31]}}, scale_q};
		if (tot_sum[48] != tot_sum[47])
			tot_sat = tot_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			tot_sat = tot_sum[47:0];

		out_free   = !out_valid_q || out_ready;
		head_first = head.first_locus || in_first_q;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			hfsl_pkg::B_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					if (head.op == hfsl_pkg::OP_TRANS)
						state_d = head_first ? hfsl_pkg::B_IDLE : hfsl_pkg::B_TR_MUL;
					else if (!head.to_ok)
						state_d = hfsl_pkg::B_CHK;
					else
						state_d = head_first ? hfsl_pkg::B_PRI_STEP : hfsl_pkg::B_EM_HI;
				end
			end
			hfsl_pkg::B_TR_MUL:   state_d = hfsl_pkg::B_TR_ADD;
			hfsl_pkg::B_TR_ADD:   state_d = hfsl_pkg::B_IDLE;
			hfsl_pkg::B_PRI_STEP: state_d = (cnt_q == n_m1) ? hfsl_pkg::B_PRI_MUL
			                                               : hfsl_pkg::B_PRI_UPD;
			hfsl_pkg::B_PRI_UPD:  state_d = hfsl_pkg::B_PRI_STEP;
			hfsl_pkg::B_PRI_MUL:  state_d = hfsl_pkg::B_PRI_WR;
			hfsl_pkg::B_PRI_WR:   state_d = hfsl_pkg::B_CHK;
			hfsl_pkg::B_EM_HI:    state_d = hfsl_pkg::B_EM_LO;
			hfsl_pkg::B_EM_LO:    state_d = hfsl_pkg::B_EM_WR;
			hfsl_pkg::B_EM_WR:    state_d = hfsl_pkg::B_CHK;
			hfsl_pkg::B_CHK:      state_d = ent_q.locus_done ? hfsl_pkg::B_SUM
			                                                 : hfsl_pkg::B_IDLE;
			hfsl_pkg::B_SUM:      if (idx_q == n_active) state_d = hfsl_pkg::B_ZCHK;
			hfsl_pkg::B_ZCHK:     state_d = (sum_q == '0) ? hfsl_pkg::B_TOT : hfsl_pkg::B_LZ;
			hfsl_pkg::B_LZ:       if (lz_q[hfsl_pkg::SUM_W-1]) state_d = hfsl_pkg::B_SQ_MUL;
			hfsl_pkg::B_SQ_MUL:   state_d = (32'(cnt_q) == hfsl_pkg::LOG_STEPS)
			                                ? hfsl_pkg::B_LN_MUL : hfsl_pkg::B_SQ_UPD;
			hfsl_pkg::B_SQ_UPD:   state_d = hfsl_pkg::B_SQ_MUL;
			hfsl_pkg::B_LN_MUL:   state_d = hfsl_pkg::B_LN_RND;
			hfsl_pkg::B_LN_RND:   state_d = hfsl_pkg::B_DV_INIT;
			hfsl_pkg::B_DV_INIT: begin
				if (32'(idx_q) == MAX_STATES)
					state_d = hfsl_pkg::B_TOT;
				else if (idx_q < n_active)
					state_d = hfsl_pkg::B_DV_STEP;
			end
			hfsl_pkg::B_DV_STEP:  if (32'(cnt_q) == hfsl_pkg::DIV_STEPS - 1)
			                          state_d = hfsl_pkg::B_DV_RND;
			hfsl_pkg::B_DV_RND:   state_d = hfsl_pkg::B_DV_INIT;
			hfsl_pkg::B_TOT:      if (out_free) state_d = hfsl_pkg::B_IDLE;
			default:              state_d = hfsl_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hfsl_pkg::B_IDLE;
		else
			state_q <= state_d;
	end

	// forward vectors, total, first-locus flag and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_STATES; i++) begin
				prev_q[i] <= '0;
				acc_q[i]  <= '0;
			end
			total_q     <= '0;
			in_first_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != hfsl_pkg::B_TOT)
				out_valid_q <= 1'b0;
			case (state_q)
				hfsl_pkg::B_TR_ADD:
					acc_q[acc_ra] <= tr_sum[48] ? hfsl_pkg::ACC_MAX : tr_sum[47:0];
				hfsl_pkg::B_PRI_WR:
					acc_q[acc_ra] <= hfsl_pkg::ACC_W'(rnd31[64:31]);
				hfsl_pkg::B_EM_WR:
					acc_q[acc_ra] <= em_full[78:31];
				hfsl_pkg::B_DV_INIT:
					if (32'(idx_q) < MAX_STATES && !(idx_q < n_active))
						prev_q[ST_W'(idx_q)] <= '0;
				hfsl_pkg::B_DV_RND:
					prev_q[ST_W'(idx_q)] <= (dv_q1 > 33'(hfsl_pkg::ONE_Q31))
					                        ? hfsl_pkg::ONE_Q31 : dv_q1[31:0];
				hfsl_pkg::B_TOT: begin
					if (out_free) begin
						for (int i = 0; i < MAX_STATES; i++)
							acc_q[i] <= '0;
						total_q     <= tot_sat;
						in_first_q  <= ent_q.seq_end;
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			hfsl_pkg::B_IDLE: begin
				ent_q   <= head;
				first_q <= head_first;
				cnt_q   <= '0;
				pri_q   <= hfsl_pkg::MUL_A_W'(
					hfsl_pkg::binom_coef(4'(n_m1), 4'(head.to_state))) << 31;
			end
			hfsl_pkg::B_PRI_UPD: begin
				pri_q <= pri_upd[59:16];
				cnt_q <= cnt_q + 1'b1;
			end
			hfsl_pkg::B_EM_LO:  ahi_q <= prod_q[55:0];
			hfsl_pkg::B_CHK: begin
				idx_q <= '0;
				sum_q <= '0;
			end
			hfsl_pkg::B_SUM: begin
				if (idx_q != n_active) begin
					sum_q <= sum_q + hfsl_pkg::SUM_W'(acc_rd);
					idx_q <= idx_q + 1'b1;
				end
			end
			hfsl_pkg::B_ZCHK: begin
				zero_q  <= sum_q == '0;
				scale_q <= {1'b1, 31'd0};
				lz_q    <= sum_q;
				e_q     <= 6'(hfsl_pkg::SUM_W - 1);
			end
			hfsl_pkg::B_LZ: begin
				// one position per cycle until the leading one reaches the top
				if (!lz_q[hfsl_pkg::SUM_W-1]) begin
					lz_q <= {lz_q[hfsl_pkg::SUM_W-2:0], 1'b0};
					e_q  <= e_q - 1'b1;
				end else begin
					x_q    <= lz_q[hfsl_pkg::SUM_W-1 -: 31];
					cnt_q  <= '0;
					frac_q <= '0;
				end
			end
			hfsl_pkg::B_SQ_UPD: begin
				if (sq_t[31]) begin
					x_q    <= sq_t[31:1];
					frac_q <= {frac_q[26:0], 1'b1};
				end else begin
					x_q    <= sq_t[30:0];
					frac_q <= {frac_q[26:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			hfsl_pkg::B_LN_MUL: neg_q <= v_w[34];
			hfsl_pkg::B_LN_RND: begin
				scale_q <= neg_q ? -$signed({1'b0, ln_rnd[64:34]})
				                 : $signed({1'b0, ln_rnd[64:34]});
				idx_q   <= '0;
			end
			hfsl_pkg::B_DV_INIT: begin
				cnt_q <= '0;
				r_q   <= (hfsl_pkg::SUM_W + 1)'(acc_rd);
				q_q   <= '0;
				if (!(idx_q < n_active) && 32'(idx_q) < MAX_STATES)
					idx_q <= idx_q + 1'b1;
			end
			hfsl_pkg::B_DV_STEP: begin
				r_q   <= dv_ge ? dv_rr - {1'b0, sum_q} : dv_rr;
				q_q   <= dv_qq | 33'(dv_ge);
				cnt_q <= cnt_q + 1'b1;
			end
			hfsl_pkg::B_DV_RND: idx_q <= idx_q + 1'b1;
			hfsl_pkg::B_TOT: begin
				if (out_free) begin
					res_scale_q <= scale_q;
					res_tot_q   <= tot_sat;
					res_zero_q  <= zero_q;
					res_final_q <= ent_q.seq_end;
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign locus_log_scale  = res_scale_q;
	assign running_log_like = res_tot_q;
	assign zero_sum         = res_zero_q;
	assign final_res        = res_final_q;

	a_result_from_close: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == hfsl_pkg::B_TOT))
		else $error("result raised outside a locus close");

	a_mantissa_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hfsl_pkg::B_SQ_MUL) |-> x_q[30])
		else $error("log mantissa lost its leading one");

	a_log_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hfsl_pkg::B_LN_MUL) |-> sum_q != '0)
		else $error("log taken of a zero sum");

endmodule

FILE: hdl/hmm_forward_scaled_loglike_unit.sv
// top level of the scaled hmm forward unit: configuration registers, front end,
// entry queue and back end; depends on hfsl_pkg, hfsl_front, hfsl_queue, hfsl_back
//
// channel  dir  handshake                   payload
// cfg      in   cfg_wr_en                   cfg_index, cfg_data
// in       in   in_valid / in_ready         op, from_state, to_state, prob, flags
// out      out  out_valid / out_ready       locus_log_scale, running_log_like, flags
//
// transition entry: a multiply and an accumulate in the back end; emission: a
// split multiply and a write, or at a first locus (n active states) a prior
// that takes one multiply per factor; a locus close sums the n accumulators
// and, unless the sum is zero, shifts the leading one to the top, takes the log
// (28 squarings on the shared multiplier) and runs the bit-serial normalise divider
// per active state, clearing unused state slots; it then loads the result register
// the front end takes a transfer whenever the four-entry queue has room, so
// input and output stall independently; the result register holds one result
// reset loads the configuration defaults, clears forward vectors, total and control,
// and sets the first-locus flag
`timescale 1ns / 1ps

module hmm_forward_scaled_loglike_unit #(
	parameter int MAX_STATES = hfsl_pkg::MAX_STATES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [hfsl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hfsl_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  op,
	input  logic [2:0]                            from_state,
	input  logic [2:0]                            to_state,
	input  logic [hfsl_pkg::PROB_W-1:0]           prob,
	input  logic                                  first_locus,
	input  logic                                  locus_done,
	input  logic                                  sequence_end,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [hfsl_pkg::SCALE_W-1:0]   locus_log_scale,
	output logic signed [hfsl_pkg::TOT_W-1:0]     running_log_like,
	output logic                                  zero_sum,
	output logic                                  final_res
);

	localparam int N_W = $clog2(MAX_STATES + 1);

	logic [hfsl_pkg::FRAC_W-1:0] prior_frac_q;
	logic [3:0]                  state_count_q;
	logic [N_W-1:0]              n_active;

	hfsl_pkg::entry_t  fe_entry;
	hfsl_pkg::entry_t  head;
	hfsl_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_frac_q  <= hfsl_pkg::PRIOR_FRAC_RST;
			state_count_q <= hfsl_pkg::STATE_CNT_RST;
		end else if (cfg_wr_en) begin
			if (hfsl_pkg::cfg_idx_t'(cfg_index) == hfsl_pkg::CFG_PRIOR_FRAC)
				prior_frac_q <= cfg_data;
			else if (hfsl_pkg::cfg_idx_t'(cfg_index) == hfsl_pkg::CFG_STATE_COUNT)
				state_count_q <= cfg_data[3:0];
		end
	end

	// active state count clamped to one up to the storage depth
	always_comb begin
		if (state_count_q == 4'd0)
			n_active = N_W'(1);
		else if (32'(state_count_q) > MAX_STATES)
			n_active = N_W'(MAX_STATES);
		else
			n_active = N_W'(state_count_q);
	end

	hfsl_front #(.MAX_STATES(MAX_STATES)) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.from_state   (from_state),
		.to_state     (to_state),
		.prob         (prob),
		.first_locus  (first_locus),
		.locus_done   (locus_done),
		.sequence_end (sequence_end),
		.n_active     (n_active),
		.q_stat       (q_stat),
		.push         (push),
		.entry        (fe_entry)
	);

	hfsl_queue #(.DEPTH(hfsl_pkg::QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (fe_entry),
		.pop      (pop),
		.rd_entry (head),
		.stat     (q_stat)
	);

	hfsl_back #(.MAX_STATES(MAX_STATES)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.n_active         (n_active),
		.prior_frac       (prior_frac_q),
		.head             (head),
		.q_stat           (q_stat),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.locus_log_scale  (locus_log_scale),
		.running_log_like (running_log_like),
		.zero_sum         (zero_sum),
		.final_res        (final_res)
	);

endmodule

FILE: test/hmm_forward_scaled_loglike_unit_tb.sv
// self-checking bench for the scaled hmm forward unit: directed and random loci
// predicts each locus result in-bench; depends on hfsl_pkg and the unit under test
`timescale 1ns / 1ps

module hmm_forward_scaled_loglike_unit_tb;

	localparam int NST = 8;
	localparam longint unsigned ONE = 64'h8000_0000;
	localparam logic [31:0] P_ONE = 32'h8000_0000;
	localparam longint unsigned AMAX = 64'hFFFF_FFFF_FFFF;
	localparam longint TMAX = 64'sd140737488355327;
	localparam longint TMIN = -64'sd140737488355328;
	localparam int WD_LIMIT = 20000;
	localparam int HOLD_CYCLES = 800;

	typedef struct {
		logic [31:0] scale;
		logic [47:0] total;
		logic        zero;
		logic        fin;
	} locus_res_t;

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [hfsl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [hfsl_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic op;
	logic [2:0] from_state, to_state;
	logic [31:0] prob;
	logic first_locus, locus_done, sequence_end;
	logic out_valid, out_ready;
	logic signed [31:0] locus_log_scale;
	logic signed [47:0] running_log_like;
	logic zero_sum, final_res;

	hmm_forward_scaled_loglike_unit u_top (.*);

	// predictor state
	int unsigned frac_q16 = 655;
	int unsigned cnt_reg = 2;
	longint unsigned fwd_prev [NST];
	longint unsigned fwd_acc [NST];
	longint log_total;
	bit first_flag = 1;

	locus_res_t pending_res [$];
	int errors = 0, n_items = 0, n_results = 0, n_zero = 0, n_final = 0;
	int idle_pct = 21;
	bit hold_rx = 0;
	int wd = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic int unsigned states_in_use();
		if (cnt_reg < 1) return 1;
		if (cnt_reg > NST) return NST;
		return cnt_reg;
	endfunction

	function automatic longint unsigned prior_q31(int unsigned z, int unsigned n);
		longint unsigned c = 1, p, f = frac_q16, g = 65536 - frac_q16;
		for (int i = 0; i < z; i++) c = c * (n - i) / (i + 1);
		p = c << 31;
		for (int i = 0; i < z; i++) p = (p * f + 32768) >> 16;
		for (int i = z; i < n; i++) p = (p * g + 32768) >> 16;
		return p > ONE ? ONE : p;
	endfunction

	function automatic longint unsigned scale_acc(longint unsigned a, longint unsigned p);
		longint unsigned hi = (a >> 24) * p;
		longint unsigned lo = (a & 64'hFF_FFFF) * p + (64'd1 << 30);
		return (hi >> 7) + ((((hi & 127) << 24) + lo) >> 31);
	endfunction

	function automatic longint unsigned norm_q31(longint unsigned a, longint unsigned s);
		longint unsigned q = 0, r = a;
		if (r >= s) begin
			r -= s;
			q = 1;
		end
		for (int i = 0; i < 31; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= s) begin
				r -= s;
				q |= 1;
			end
		end
		if (2 * r >= s) q++;
		return q > ONE ? ONE : q;
	endfunction

	function automatic longint ln_q8_24(longint unsigned s);
		int e = 63;
		longint unsigned x, fr = 0, mag, r;
		longint v;
		while (s[e] == 0) e--;
		x = (e >= 30) ? (s >> (e - 30)) : (s << (30 - e));
		for (int i = 0; i < 28; i++) begin
			x = (x * x) >> 30;
			fr <<= 1;
			if (x >= (64'd1 << 31)) begin
				x >>= 1;
				fr |= 1;
			end
		end
		v = longint'(e - 31) * 268435456 + longint'(fr);
		mag = (v < 0) ? longint'(-v) : v;
		r = (mag * 744261118 + (64'd1 << 33)) >> 34;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	// advance the forward state by one entry, queue a result on a locus close
	task automatic predict_entry(hfsl_pkg::op_t o, int unsigned fs, int unsigned ts,
			longint unsigned pr, bit fl, bit dn, bit se);
		int unsigned n;
		longint unsigned p, s, t;
		longint sc, tot;
		bit first, zr;
		locus_res_t r;
		n = states_in_use();
		p = pr > ONE ? ONE : pr;
		first = fl || first_flag;
		s = 0;
		if (o == hfsl_pkg::OP_TRANS) begin
			if (!first && fs < n && ts < n) begin
				t = fwd_acc[ts] + ((fwd_prev[fs] * p + (64'd1 << 30)) >> 31);
				fwd_acc[ts] = t > AMAX ? AMAX : t;
			end
			return;
		end
		if (ts < n) begin
			if (first) fwd_acc[ts] = (prior_q31(ts, n - 1) * p + (64'd1 << 30)) >> 31;
			else fwd_acc[ts] = scale_acc(fwd_acc[ts], p);
		end
		if (!dn) return;
		for (int z = 0; z < n; z++) s += fwd_acc[z];
		zr = (s == 0);
		if (zr) sc = -64'sd2147483648;
		else begin
			sc = ln_q8_24(s);
			for (int z = 0; z < NST; z++) fwd_prev[z] = (z < n) ? norm_q31(fwd_acc[z], s) : 0;
		end
		tot = (first ? 0 : log_total) + sc;
		if (tot > TMAX) tot = TMAX;
		if (tot < TMIN) tot = TMIN;
		log_total = tot;
		for (int z = 0; z < NST; z++) fwd_acc[z] = 0;
		first_flag = se;
		r.scale = sc[31:0];
		r.total = tot[47:0];
		r.zero = zr;
		r.fin = se;
		pending_res.push_back(r);
	endtask

	// valid stays high across back-to-back transfers and drops only when idling
	task automatic send_entry(hfsl_pkg::op_t o, int unsigned fs, int unsigned ts,
			logic [31:0] pr, bit fl, bit dn, bit se);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1;
		op <= o;
		from_state <= 3'(fs);
		to_state <= 3'(ts);
		prob <= pr;
		first_locus <= fl;
		locus_done <= dn;
		sequence_end <= se;
		do @(posedge clk); while (!in_ready);
		predict_entry(o, fs, ts, pr, fl, dn, se);
		n_items++;
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task automatic write_reg(hfsl_pkg::cfg_idx_t idx, int unsigned val);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		@(posedge clk);
		cfg_wr_en <= 0;
		if (idx == hfsl_pkg::CFG_PRIOR_FRAC) frac_q16 = val & 16'hFFFF;
		else cnt_reg = val & 4'hF;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_prob();
		case ($urandom_range(5))
			0: return P_ONE;
			1: return $urandom;
			2: return 0;
			default: return $urandom_range(32'h8000_0000, 32'h0100_0000);
		endcase
	endfunction

	// one locus: transitions unless first, then one emission per state (indices scrambled when noisy)
	task automatic send_locus(bit fl, bit se, bit noisy);
		int unsigned n;
		n = states_in_use();
		if (!fl && !first_flag)
			for (int t = 0; t < n; t++)
				for (int f = 0; f < n; f++)
					send_entry(hfsl_pkg::OP_TRANS, f, t, rand_prob(), 0,
						1'($urandom_range(1)), 1'($urandom_range(1)));
		for (int t = 0; t < n; t++)
			send_entry(hfsl_pkg::OP_EMIT, noisy ? $urandom_range(7) : 0,
				noisy && $urandom_range(3) == 0 ? $urandom_range(7) : t,
				rand_prob(), fl, t == n - 1, (t == n - 1) ? se : 1'($urandom_range(1)));
	endtask

	task automatic test_directed();
		write_reg(hfsl_pkg::CFG_STATE_COUNT, 2);
		write_reg(hfsl_pkg::CFG_PRIOR_FRAC, 0);
		send_locus(1, 0, 0);
		send_entry(hfsl_pkg::OP_TRANS, 0, 0, 32'hFFFF_FFFF, 0, 1, 1);
		send_entry(hfsl_pkg::OP_TRANS, 1, 1, P_ONE, 0, 0, 0);
		send_entry(hfsl_pkg::OP_TRANS, 7, 0, P_ONE, 0, 0, 0);
		send_entry(hfsl_pkg::OP_EMIT, 0, 0, P_ONE, 0, 0, 1);
		send_entry(hfsl_pkg::OP_EMIT, 0, 5, P_ONE, 0, 1, 0);
		// zero sum on an all-zero locus
		send_entry(hfsl_pkg::OP_EMIT, 0, 0, 0, 0, 0, 0);
		send_entry(hfsl_pkg::OP_EMIT, 0, 1, 0, 0, 1, 1);
		send_entry(hfsl_pkg::OP_EMIT, 7, 7, 32'hFFFF_FFFF, 1, 1, 1);
		wait_drained();
		write_reg(hfsl_pkg::CFG_STATE_COUNT, 0);
		write_reg(hfsl_pkg::CFG_PRIOR_FRAC, 65535);
		send_locus(1, 0, 0);
		send_entry(hfsl_pkg::OP_TRANS, 0, 0, P_ONE, 0, 0, 0);
		send_entry(hfsl_pkg::OP_EMIT, 0, 0, P_ONE, 0, 1, 1);
		wait_drained();
	endtask

	task automatic run_phase(int unsigned cnt, int unsigned frac, int unsigned loci, int pct);
		write_reg(hfsl_pkg::CFG_STATE_COUNT, cnt);
		write_reg(hfsl_pkg::CFG_PRIOR_FRAC, frac);
		idle_pct = pct;
		for (int i = 0; i < loci; i++) begin
			if ($urandom_range(9) == 0)
				send_entry(hfsl_pkg::op_t'($urandom_range(1)), $urandom_range(7),
					$urandom_range(7), $urandom, 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else send_locus($urandom_range(7) == 0, $urandom_range(5) == 0,
				$urandom_range(7) == 0);
		end
		wait_drained();
	endtask

	// receiver holds off for a fixed stretch while loci keep arriving
	task automatic test_backpressure();
		write_reg(hfsl_pkg::CFG_STATE_COUNT, 2);
		fork
			begin
				hold_rx = 1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 0;
			end
		join_none
		for (int i = 0; i < 12; i++) send_locus(i == 0, 0, 0);
		wait_drained();
	endtask

	task automatic test_random();
		run_phase(2, 655, 40, 21);
		run_phase(1, 32768, 40, 21);
		run_phase(8, 65535, 8, 0);
		run_phase(15, 1, 6, 21);
		run_phase(4, $urandom_range(65535), 20, 21);
		run_phase(3, $urandom_range(65535), 30, 21);
		run_phase(6, 0, 8, 21);
	endtask

	always @(posedge clk) begin
		if (!hold_rx) out_ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
		else out_ready <= 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			locus_res_t e;
			n_results++;
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result scale %h total %h", $time,
					locus_log_scale, running_log_like);
				errors++;
			end else begin
				e = pending_res.pop_front();
				if (zero_sum) n_zero++;
				if (final_res) n_final++;
				if (locus_log_scale !== e.scale || running_log_like !== e.total
						|| zero_sum !== e.zero || final_res !== e.fin) begin
					$display("%0t: mismatch exp scale %h total %h zero %b fin %b", $time,
						e.scale, e.total, e.zero, e.fin);
					$display("%0t:          got scale %h total %h zero %b fin %b", $time,
						locus_log_scale, running_log_like, zero_sum, final_res);
					errors++;
				end
			end
		end
	end

	// stall watchdog on either transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || hold_rx
				|| (!in_valid && pending_res.size() == 0)) wd <= 0;
		else wd <= wd + 1;
		if (wd >= WD_LIMIT) begin
			$display("hmm_forward_scaled_loglike_unit_tb: FAIL");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		out_ready = 0;
		op = 0;
		from_state = 0;
		to_state = 0;
		prob = 0;
		first_locus = 0;
		locus_done = 0;
		sequence_end = 0;
		log_total = 0;
		for (int z = 0; z < NST; z++) begin
			fwd_prev[z] = 0;
			fwd_acc[z] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		$display("covered %0d entries, %0d locus results (%0d zero sum, %0d sequence ends)",
			n_items, n_results, n_zero, n_final);
		$display("several state counts incl. clamped ones, prior fraction extremes, stalls both sides");
		if (errors == 0 && pending_res.size() == 0)
			$display("hmm_forward_scaled_loglike_unit_tb: PASS");
		else
			$display("hmm_forward_scaled_loglike_unit_tb: FAIL");
		$finish;
	end

endmodule
